// ===== rtl/matrix_vector_multiply_unit_defines.svh =====
// assertion macros shared by the matrix vector multiply checkers
// expects clk and rst to be visible where a macro is used
`ifndef MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH

// concurrent check, disabled while reset is asserted
`define MVM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("matrix vector multiply check failed");

// concurrent check that also runs through reset
`define MVM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("matrix vector multiply reset check failed");

`endif

// ===== rtl/mvm_pkg.sv =====
// shared types and constants of the matrix vector multiply unit
// no dependencies
`timescale 1ns / 1ps

package mvm_pkg;

  // fixed field widths of the request and result transactions
  localparam int REQ_W      = 2;
  localparam int IDX_FIELD_W = 4;
  localparam int VALUE_W    = 16;
  localparam int ACC_W      = 40;
  localparam int SIZE_W     = 5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd4;

  // request type codes
  localparam logic [REQ_W-1:0] REQ_MATRIX  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_VECTOR  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic wr_matrix;
    logic wr_vector;
    logic start;
    logic issue;
    logic next_row;
    logic load_out;
  } mvm_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic n_zero;
    logic j_last;
    logic i_last;
    logic row_done;
    logic out_free;
  } mvm_status_t;

endpackage

// ===== rtl/mvm_if.sv =====
// request and result channel interfaces of the matrix vector multiply unit
// depends on mvm_pkg
`timescale 1ns / 1ps

// request channel: loads and compute commands
interface mvm_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [mvm_pkg::REQ_W-1:0]            req_type;
  logic [mvm_pkg::IDX_FIELD_W-1:0]      row_index;
  logic [mvm_pkg::IDX_FIELD_W-1:0]      col_index;
  logic signed [mvm_pkg::VALUE_W-1:0]   value;

  modport source (output valid, req_type, row_index, col_index, value, input ready);
  modport sink   (input valid, req_type, row_index, col_index, value, output ready);
endinterface

// result channel: one transaction per row in use
interface mvm_res_if;
  logic                                 valid;
  logic                                 ready;
  logic [mvm_pkg::IDX_FIELD_W-1:0]      out_row;
  logic signed [mvm_pkg::ACC_W-1:0]     product;
  logic                                 last;

  modport source (output valid, out_row, product, last, input ready);
  modport sink   (input valid, out_row, product, last, output ready);
endinterface

// ===== rtl/mvm_ram.sv =====
// generic simple dual port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module mvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/mvm_ctrl.sv =====
// controller state machine of the matrix vector multiply unit
// depends on mvm_pkg
`timescale 1ns / 1ps

module mvm_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic [mvm_pkg::REQ_W-1:0]  req_type,
  output logic                       in_ready,
  input  mvm_pkg::mvm_status_t       status,
  output mvm_pkg::mvm_cmd_t          cmd
);

  import mvm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = req_valid && in_ready;

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.wr_matrix = accept && (req_type == REQ_MATRIX);
    cmd.wr_vector = accept && (req_type == REQ_VECTOR);
    case (state)
      S_IDLE: begin
        if (accept && (req_type == REQ_COMPUTE) && !status.n_zero) begin
          cmd.start  = 1'b1;
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (status.j_last) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (status.row_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          if (status.i_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.next_row = 1'b1;
            state_next   = S_ISSUE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/mvm_datapath.sv =====
// datapath of the matrix vector multiply unit: stores, counters,
// multiply accumulate pipeline, size register and result register
// depends on mvm_pkg and mvm_ram
`timescale 1ns / 1ps

module mvm_datapath #(
  parameter int MAX_DIM    = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mvm_pkg::SIZE_W-1:0]          cfg_wdata,
  input  logic [mvm_pkg::IDX_FIELD_W-1:0]     row_index,
  input  logic [mvm_pkg::IDX_FIELD_W-1:0]     col_index,
  input  logic signed [mvm_pkg::VALUE_W-1:0]  value,
  input  mvm_pkg::mvm_cmd_t                   cmd,
  output mvm_pkg::mvm_status_t                status,
  input  logic                                res_ready,
  output logic                                res_valid,
  output logic [mvm_pkg::IDX_FIELD_W-1:0]     res_row,
  output logic signed [mvm_pkg::ACC_W-1:0]    res_product,
  output logic                                res_last
);

  import mvm_pkg::*;

  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int CNT_W     = (IDX_W > SIZE_W) ? IDX_W : SIZE_W;
  localparam int MAT_DEPTH = 1 << (2 * IDX_W);
  localparam int MUL_W     = 2 * VALUE_BITS;
  localparam int SUM_W     = ((MUL_W > ACC_W) ? MUL_W : ACC_W) + 1;
  localparam int DIM_CAP   = (MAX_DIM < 31) ? MAX_DIM : 31;

  logic [SIZE_W-1:0]        size_in_use;
  logic [SIZE_W-1:0]        n;
  logic [CNT_W-1:0]         n_ext;
  logic [CNT_W-1:0]         i, j;
  logic                     row_ok, col_ok;
  logic [VALUE_BITS-1:0]    wr_value;
  logic [VALUE_BITS-1:0]    m_rdata, v_rdata;
  logic                     s1_valid, s1_first, s1_last;
  logic                     s2_valid, s2_first, s2_last;
  logic signed [MUL_W-1:0]  prod;
  logic signed [ACC_W-1:0]  acc, acc_next, base;
  logic signed [SUM_W-1:0]  sum;
  logic                     row_done;

  // size register, reset value from the package
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_RESET;
    end else if (cfg_we) begin
      size_in_use <= cfg_wdata;
    end
  end

  // size in use, capped at the store dimension
  assign n     = (size_in_use > SIZE_W'(DIM_CAP)) ? SIZE_W'(DIM_CAP) : size_in_use;
  assign n_ext = CNT_W'(n);

  // row and column counters
  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
      j <= '0;
    end else if (cmd.start) begin
      i <= '0;
      j <= '0;
    end else if (cmd.next_row) begin
      i <= i + CNT_W'(1);
      j <= '0;
    end else if (cmd.issue) begin
      j <= j + CNT_W'(1);
    end
  end

  // load path: out of range indexes are dropped, value kept as low bits
  assign row_ok   = (32'(row_index) < MAX_DIM);
  assign col_ok   = (32'(col_index) < MAX_DIM);
  assign wr_value = VALUE_BITS'($unsigned(value));

  mvm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAT_DEPTH)
  ) u_matrix_ram (
    .clk   (clk),
    .we    (cmd.wr_matrix && row_ok && col_ok),
    .waddr ({IDX_W'(row_index), IDX_W'(col_index)}),
    .wdata (wr_value),
    .re    (cmd.issue),
    .raddr ({i[IDX_W-1:0], j[IDX_W-1:0]}),
    .rdata (m_rdata)
  );

  mvm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_DIM)
  ) u_vector_ram (
    .clk   (clk),
    .we    (cmd.wr_vector && row_ok),
    .waddr (IDX_W'(row_index)),
    .wdata (wr_value),
    .re    (cmd.issue),
    .raddr (j[IDX_W-1:0]),
    .rdata (v_rdata)
  );

  // pipeline control: read stage then multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      row_done <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
      row_done <= s2_valid && s2_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= (j == '0);
    s1_last  <= (j == n_ext - CNT_W'(1));
    s2_first <= s1_first;
    s2_last  <= s1_last;
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      prod <= $signed(m_rdata) * $signed(v_rdata);
    end
  end

  // saturating accumulate, restarted on the first column of a row
  always_comb begin
    base = s2_first ? '0 : acc;
    sum  = SUM_W'(base) + SUM_W'(prod);
    if ((&sum[SUM_W-1:ACC_W-1]) || (~|sum[SUM_W-1:ACC_W-1])) begin
      acc_next = sum[ACC_W-1:0];
    end else if (sum[SUM_W-1]) begin
      acc_next = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      acc_next = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      acc <= acc_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_row     <= IDX_FIELD_W'(i);
      res_product <= acc;
      res_last    <= status.i_last;
    end
  end

  // status to the controller
  assign status.n_zero   = (size_in_use == '0);
  assign status.j_last   = (j == n_ext - CNT_W'(1));
  assign status.i_last   = (i == n_ext - CNT_W'(1));
  assign status.row_done = row_done;
  assign status.out_free = !res_valid || res_ready;

endmodule

// ===== rtl/matrix_vector_multiply_unit.sv =====
// Square matrix times vector in signed fixed point.
// Request channel req: req_type selects a matrix entry write (row_index,
// col_index, value), a vector element write (row_index, value) or a compute.
// Values are Q8.8; writes with an index at or beyond MAX_DIM are dropped.
// Result channel res: a compute gives one transaction per row in use, with
// out_row, the saturated Q24.16 product and last on the final row.
// cfg_we / cfg_wdata set the size in use (reset 4, capped at MAX_DIM); a
// size of zero makes a compute give nothing.
// Loads may arrive back to back while no compute is running.
// A compute holds req.ready low until its last result is in the output
// register; each row makes n reads through the single read port of each
// store, then passes the ram read, multiply and accumulate stages.
// The output register lets a new request be taken while the last result
// still waits; a stalled receiver holds the result and pauses the row walk.
// Reset clears the controller, pipeline valids and the output valid and
// restores the size; the stores are not cleared.
// depends on mvm_pkg, mvm_if, mvm_ctrl, mvm_datapath
`timescale 1ns / 1ps

module matrix_vector_multiply_unit #(
  parameter int MAX_DIM    = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [mvm_pkg::SIZE_W-1:0] cfg_wdata,
  mvm_req_if.sink                    req,
  mvm_res_if.source                  res
);

  import mvm_pkg::*;

  mvm_cmd_t    cmd;
  mvm_status_t status;
  logic        in_ready;

  assign req.ready = in_ready;

  mvm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mvm_datapath #(
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .row_index   (req.row_index),
    .col_index   (req.col_index),
    .value       (req.value),
    .cmd         (cmd),
    .status      (status),
    .res_ready   (res.ready),
    .res_valid   (res.valid),
    .res_row     (res.out_row),
    .res_product (res.product),
    .res_last    (res.last)
  );

endmodule

// ===== rtl/mvm_checker.sv =====
// port level checks of the matrix vector multiply unit, bound to the top level
// depends on matrix_vector_multiply_unit_defines.svh and mvm_pkg
`timescale 1ns / 1ps
`include "matrix_vector_multiply_unit_defines.svh"

module mvm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_ready,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [mvm_pkg::IDX_FIELD_W-1:0] res_row,
  input logic                            res_last
);

  // reset empties the output register
  `MVM_ASSERT_ALWAYS(a_reset_clears_out, (rst |=> !res_valid))

  // a stalled result keeps its row and flag
  `MVM_ASSERT(a_res_hold, (res_valid && !res_ready |=> res_valid && $stable(res_row) && $stable(res_last)))

  // a new result only comes out of a running compute
  `MVM_ASSERT(a_res_from_compute, ($rose(res_valid) |-> !$past(req_ready)))

  // rows still pending keep the request side closed
  `MVM_ASSERT(a_busy_until_last, (res_valid && res_ready && !res_last |-> !req_ready))

endmodule

bind matrix_vector_multiply_unit mvm_checker u_mvm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_row   (res.out_row),
  .res_last  (res.last)
);

// ===== verif/mvm_product_checker.sv =====
// checker for the matrix vector multiply unit: tracks the stores and size,
// predicts every row result and compares the result channel against it
// depends on mvm_pkg and mvm_if
`timescale 1ns / 1ps

module mvm_product_checker #(
  parameter int MAX_DIM = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [mvm_pkg::SIZE_W-1:0] cfg_wdata,
  mvm_req_if                         req,
  mvm_res_if                         res,
  output int                         error_count,
  output int                         pending
);

  import mvm_pkg::*;

  localparam longint ACC_HIGH = 64'sd549755813887;
  localparam longint ACC_LOW  = -ACC_HIGH - 1;

  typedef struct packed {
    logic [IDX_FIELD_W-1:0] row;
    logic signed [ACC_W-1:0] product;
    logic                    last;
  } row_sum_t;

  // local copy of the block state
  logic signed [VALUE_W-1:0] entry_mem [0:MAX_DIM*MAX_DIM-1];
  logic signed [VALUE_W-1:0] elem_mem  [0:MAX_DIM-1];
  logic [SIZE_W-1:0]         size_reg;
  row_sum_t                  expected_rows [$];
  int                        mismatches;

  initial begin
    mismatches  = 0;
    error_count = 0;
    pending     = 0;
    size_reg    = SIZE_RESET;
  end

  function automatic longint clamp_q24_16(input longint x);
    if (x > ACC_HIGH) return ACC_HIGH;
    if (x < ACC_LOW) return ACC_LOW;
    return x;
  endfunction

  // one expected transaction per row in use, accumulated column by column
  task automatic predict_row_sums();
    int       n;
    longint   acc;
    row_sum_t r;
    n = (size_reg > MAX_DIM) ? MAX_DIM : int'(size_reg);
    for (int i = 0; i < n; i++) begin
      acc = 0;
      for (int j = 0; j < n; j++) begin
        acc = clamp_q24_16(acc + longint'(entry_mem[i*MAX_DIM+j]) * longint'(elem_mem[j]));
      end
      r.row     = IDX_FIELD_W'(i);
      r.product = acc[ACC_W-1:0];
      r.last    = (i == n - 1);
      expected_rows.push_back(r);
    end
  endtask

  // follow config writes, loads and computes; check each result transaction
  always @(posedge clk) begin : track
    row_sum_t want;
    if (rst) begin
      size_reg = SIZE_RESET;
      expected_rows.delete();
    end else begin
      if (cfg_we) size_reg = cfg_wdata;
      if (req.valid && req.ready) begin
        case (req.req_type)
          REQ_MATRIX:  entry_mem[req.row_index*MAX_DIM+req.col_index] = req.value;
          REQ_VECTOR:  elem_mem[req.row_index] = req.value;
          REQ_COMPUTE: predict_row_sums();
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (expected_rows.size() == 0) begin
          $error("result transaction with none expected: out_row %0d product %0d last %0b",
                 res.out_row, res.product, res.last);
          mismatches++;
        end else begin
          want = expected_rows.pop_front();
          if (res.out_row !== want.row) begin
            $error("out_row mismatch: expected %0d, actual %0d", want.row, res.out_row);
            mismatches++;
          end
          if (res.product !== want.product) begin
            $error("product mismatch: expected %0d, actual %0d", want.product, res.product);
            mismatches++;
          end
          if (res.last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, res.last);
            mismatches++;
          end
        end
      end
    end
    pending     <= expected_rows.size();
    error_count <= mismatches;
  end

endmodule

// ===== verif/tb_matrix_vector_multiply_unit.sv =====
// testbench top for the matrix vector multiply unit: clock, reset, request
// stimulus over several sizes and idle patterns, and the final verdict
// depends on mvm_pkg, mvm_if, matrix_vector_multiply_unit and mvm_product_checker
`timescale 1ns / 1ps

module tb_matrix_vector_multiply_unit;

  import mvm_pkg::*;

  localparam int MAX_DIM      = 16;
  localparam int DRAIN_CYCLES = 400;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_ITEMS  = 12;
  localparam int NUM_PHASES   = 9;

  // request type with no operation behind it
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;
  int                error_count;
  int                pending;
  int                cycle_count;

  mvm_req_if req_ch ();
  mvm_res_if res_ch ();

  matrix_vector_multiply_unit #(
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (16)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  mvm_product_checker #(
    .MAX_DIM (MAX_DIM)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req         (req_ch),
    .res         (res_ch),
    .error_count (error_count),
    .pending     (pending)
  );

  // stimulus bookkeeping
  logic [MAX_DIM*MAX_DIM-1:0] entry_written;
  logic [MAX_DIM-1:0]         elem_written;
  logic [SIZE_W-1:0]          cur_size;
  int                         send_idle_pct;
  int                         recv_idle_pct;
  int                         item_count;
  int                         phase_count;
  int                         compute_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stalls at random
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic int size_limit();
    return (cur_size > MAX_DIM) ? MAX_DIM : int'(cur_size);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return -16'sd1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // one request transaction, with a random gap in front
  task automatic send_request(input logic [REQ_W-1:0] kind,
                              input logic [IDX_FIELD_W-1:0] row,
                              input logic [IDX_FIELD_W-1:0] col,
                              input logic signed [VALUE_W-1:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.row_index <= row;
    req_ch.col_index <= col;
    req_ch.value     <= val;
    do @(posedge clk); while (!req_ch.ready);
    if (kind == REQ_MATRIX) entry_written[row*MAX_DIM+col] = 1'b1;
    if (kind == REQ_VECTOR) elem_written[row] = 1'b1;
    if (kind == REQ_COMPUTE) compute_count++;
    item_count++;
    phase_count++;
  endtask

  // random load with indices below lim
  task automatic load_random(input int lim);
    logic [IDX_FIELD_W-1:0] r;
    logic [IDX_FIELD_W-1:0] c;
    r = IDX_FIELD_W'($urandom_range(lim - 1));
    c = IDX_FIELD_W'($urandom_range(lim - 1));
    if ($urandom_range(3) == 0) send_request(REQ_VECTOR, r, c, pick_value());
    else send_request(REQ_MATRIX, r, c, pick_value());
  endtask

  // write whatever the size in use still lacks, then compute
  task automatic compute_filled();
    int n;
    n = size_limit();
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (!entry_written[i*MAX_DIM+j])
          send_request(REQ_MATRIX, IDX_FIELD_W'(i), IDX_FIELD_W'(j), pick_value());
      end
      if (!elem_written[i])
        send_request(REQ_VECTOR, IDX_FIELD_W'(i), IDX_FIELD_W'($urandom), pick_value());
    end
    send_request(REQ_COMPUTE, IDX_FIELD_W'($urandom), IDX_FIELD_W'($urandom), VALUE_W'($urandom));
  endtask

  // let every expected result arrive and the block settle
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input logic [SIZE_W-1:0] s);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_size  = s;
  endtask

  // main stimulus
  initial begin : stimulus
    logic [SIZE_W-1:0] phase_sizes [NUM_PHASES];
    logic signed [VALUE_W-1:0] edge_vals [5];
    int pick;
    int lim;
    int burst;

    phase_sizes = '{5'd1, 5'd0, 5'd9, 5'd16, 5'd2, 5'd31, 5'd5, 5'd3, 5'd12};
    edge_vals   = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sd1};

    entry_written    = '0;
    elem_written     = '0;
    cur_size         = SIZE_RESET;
    item_count       = 0;
    phase_count      = 0;
    compute_count    = 0;
    send_idle_pct    = 10;
    recv_idle_pct    = 54;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_MATRIX;
    req_ch.row_index <= '0;
    req_ch.col_index <= '0;
    req_ch.value     <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: full-scale values in the reset size, far indices, unused type
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        send_request(REQ_MATRIX, IDX_FIELD_W'(i), IDX_FIELD_W'(j), edge_vals[(i + j) % 5]);
      end
    end
    send_request(REQ_VECTOR, 4'd0, 4'd0, 16'sh7fff);
    send_request(REQ_VECTOR, 4'd1, 4'd15, 16'sh8000);
    send_request(REQ_VECTOR, 4'd2, 4'd0, -16'sd1);
    send_request(REQ_VECTOR, 4'd3, 4'd0, 16'sh7fff);
    send_request(REQ_MATRIX, 4'd15, 4'd15, 16'sh5a5a);
    send_request(REQ_VECTOR, 4'd15, 4'd7, 16'sha5a5);
    send_request(REQ_UNUSED, 4'd15, 4'd15, 16'shffff);
    send_request(REQ_COMPUTE, 4'd0, 4'd0, 16'sh0000);
    send_request(REQ_COMPUTE, 4'd15, 4'd15, 16'shffff);

    // random phases over sizes and idle patterns
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p / 3)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      set_size(phase_sizes[p]);
      phase_count = 0;
      while (phase_count < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        lim  = (size_limit() == 0) ? MAX_DIM : size_limit();
        if (pick < 55) begin
          // well-formed: loads inside the size, then a compute
          burst = $urandom_range(1, 2 * lim + 2);
          repeat (burst) load_random(lim);
          compute_filled();
        end else if (pick < 85) begin
          load_random(MAX_DIM);
        end else if (pick < 93) begin
          send_request(REQ_UNUSED, IDX_FIELD_W'($urandom), IDX_FIELD_W'($urandom),
                       VALUE_W'($urandom));
        end else begin
          compute_filled();
        end
      end
    end

    drain();
    $display("covered %0d request transactions, %0d computes, %0d size settings",
             item_count, compute_count, NUM_PHASES + 1);
    $display("idle patterns: sender-light, receiver-light and no idling");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
